// ----- hw/rtl/url_percent_decoder_core_assert.svh -----
// assertion macros for the url percent decoder core
// expects clk and rst in the scope of the module that includes this file
`ifndef URL_PERCENT_DECODER_CORE_ASSERT_SVH
`define URL_PERCENT_DECODER_CORE_ASSERT_SVH

// same-cycle implication
`define UPD_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upd assertion failed");

// next-cycle implication
`define UPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upd assertion failed");

`endif

// ----- hw/rtl/upd_pkg.sv -----
// shared types, constants, digit and plain-character helpers for the url percent decoder
// no dependencies
package upd_pkg;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CASE_OFS = 8'h20;
  localparam logic [7:0] HEX_OFS  = 8'd10;

  typedef enum logic [2:0] {
    PH_PLAIN = 3'b001,
    PH_PCT   = 3'b010,
    PH_HI    = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_last;
  } item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       has_char;
    logic       end_of_string;
  } res_t;

  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] lc;
    begin
      lc = c;
      if (c >= CH_UC_A && c <= CH_UC_Z) begin
        lc = c + CASE_OFS;
      end
      if (c >= CH_0 && c <= CH_9) begin
        digit_value = c - CH_0;
      end else begin
        digit_value = lc - CH_LC_A + HEX_OFS;
      end
    end
  endfunction

  function automatic logic [7:0] plain_map(input logic [7:0] c);
    plain_map = (c == CH_PLUS) ? CH_SPACE : c;
  endfunction

endpackage

// ----- hw/rtl/upd_in_if.sv -----
// input channel of the url percent decoder: one character per transaction
// no dependencies
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_char;
  logic       is_last;

  modport source (output valid, output in_char, output is_last, input ready);
  modport sink (input valid, input in_char, input is_last, output ready);
endinterface

// ----- hw/rtl/upd_out_if.sv -----
// output channel of the url percent decoder: one result per transaction
// no dependencies
interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       has_char;
  logic       end_of_string;

  modport source (output valid, output out_char, output has_char, output end_of_string,
                  input ready);
  modport sink (input valid, input out_char, input has_char, input end_of_string,
                output ready);
endinterface

// ----- hw/rtl/upd_in_reg.sv -----
// input register stage: captures one character transaction
// depends on upd_pkg and upd_in_if
module upd_in_reg (
  input  logic           clk,
  input  logic           rst,
  upd_in_if.sink         din,
  input  logic           advance,
  output logic           valid,
  output upd_pkg::item_t item
);
  import upd_pkg::*;

  assign din.ready = !valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (din.ready) begin
      valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && din.ready) begin
      item.in_char <= din.in_char;
      item.is_last <= din.is_last;
    end
  end
endmodule

// ----- hw/rtl/upd_decode.sv -----
// decode logic and escape state: maps one character to at most one result
// depends on upd_pkg
module upd_decode (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  upd_pkg::item_t item,
  output logic           emit,
  output upd_pkg::res_t  res
);
  import upd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_char;
  logic [7:0] held_char_next;
  logic       cut_off;
  logic       cut_off_next;
  logic       have;
  logic       have_out;
  logic [7:0] byte_val;
  logic [7:0] hi_val;

  assign hi_val = digit_value(held_char);

  always_comb begin
    phase_next     = phase;
    held_char_next = held_char;
    have           = 1'b0;
    byte_val       = plain_map(item.in_char);
    case (phase)
      PH_PCT: begin
        if (item.is_last) begin
          have = (item.in_char != CH_PCT);
        end else begin
          held_char_next = item.in_char;
          phase_next     = PH_HI;
        end
      end
      PH_HI: begin
        byte_val       = {hi_val[3:0], 4'b0000} | digit_value(item.in_char);
        have           = 1'b1;
        phase_next     = PH_PLAIN;
        held_char_next = '0;
      end
      default: begin
        if (item.in_char == CH_PCT) begin
          if (!item.is_last) begin
            phase_next = PH_PCT;
          end
        end else begin
          have = 1'b1;
        end
      end
    endcase
    cut_off_next = cut_off || (have && byte_val == 8'h00);
    have_out     = have && !cut_off_next;
    if (item.is_last) begin
      phase_next     = PH_PLAIN;
      held_char_next = '0;
      cut_off_next   = 1'b0;
    end
  end

  assign emit              = item.is_last || have_out;
  assign res.out_char      = have_out ? byte_val : 8'h00;
  assign res.has_char      = have_out;
  assign res.end_of_string = item.is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_PLAIN;
      held_char <= '0;
      cut_off   <= 1'b0;
    end else if (step) begin
      phase     <= phase_next;
      held_char <= held_char_next;
      cut_off   <= cut_off_next;
    end
  end
endmodule

// ----- hw/rtl/upd_out_reg.sv -----
// result register: holds one result transaction until the receiver takes it
// depends on upd_pkg and upd_out_if
module upd_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  upd_pkg::res_t res,
  output logic          can_load,
  upd_out_if.source     dout
);
  import upd_pkg::*;

  logic out_valid;
  res_t held;

  assign can_load           = !out_valid || dout.ready;
  assign dout.valid         = out_valid;
  assign dout.out_char      = held.out_char;
  assign dout.has_char      = held.has_char;
  assign dout.end_of_string = held.end_of_string;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      held <= res;
    end
  end
endmodule

// ----- hw/rtl/url_percent_decoder_core.sv -----
// streaming url percent decoder, top level
// depends on upd_pkg, upd_in_if, upd_out_if, upd_in_reg, upd_decode, upd_out_reg
// and url_percent_decoder_core_assert.svh
//
// din carries one character per transaction, is_last on the final one.
// dout carries decoded results: '+' gives a space, '%' and two more
// characters give one byte, a decoded zero byte cuts off the rest of the
// string. the final character always gives a result with end_of_string set.
// an escape in progress gives no result for its first two characters.
// a character that produces a result passes the input register, then the
// result register, before it shows on dout.
// throughput: one character per cycle unless dout stalls, set by the single
// decode stage between the two registers; the escape state updates in the
// same cycle. when dout stalls, the result register holds and the input
// register still takes one more character; din.ready falls once both are
// full. reset clears both stages and returns the escape state to plain text.
module url_percent_decoder_core (
  input  logic    clk,
  input  logic    rst,
  upd_in_if.sink  din,
  upd_out_if.source dout
);
  import upd_pkg::*;

  logic  s1_valid;
  item_t s1_item;
  logic  can_load;
  logic  advance;
  logic  emit;
  res_t  res;

  assign advance = s1_valid && can_load;

  upd_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .din     (din),
    .advance (advance),
    .valid   (s1_valid),
    .item    (s1_item)
  );

  upd_decode u_decode (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .item (s1_item),
    .emit (emit),
    .res  (res)
  );

  upd_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .res      (res),
    .can_load (can_load),
    .dout     (dout)
  );

`include "url_percent_decoder_core_assert.svh"

  `UPD_ASSERT_IMPLIES(a_no_zero_byte, dout.valid && dout.has_char, dout.out_char != 8'h00)
  `UPD_ASSERT_IMPLIES(a_mid_has_byte, dout.valid && !dout.end_of_string, dout.has_char)
  `UPD_ASSERT_NEXT(a_last_closes, advance && s1_item.is_last, dout.valid && dout.end_of_string)

endmodule
